>>> hdl/arpc_pkg.sv
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int OPCODE_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd2;

  localparam logic [OPCODE_W-1:0] ARP_OPCODE_REQUEST = 16'd1;

  typedef enum logic {
    OP_LEARN   = 1'b0,
    OP_RESOLVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

endpackage

>>> hdl/arpc_in_if.sv
interface arpc_in_if;
  import arpc_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [IP_W-1:0]     peer_ip;
  logic [MAC_W-1:0]    peer_mac;
  logic [OPCODE_W-1:0] arp_opcode;
  logic [IP_W-1:0]     target_ip;

  modport source (
    output valid, operation, peer_ip, peer_mac, arp_opcode, target_ip,
    input  ready
  );

  modport sink (
    input  valid, operation, peer_ip, peer_mac, arp_opcode, target_ip,
    output ready
  );

endinterface

>>> hdl/arpc_out_if.sv
interface arpc_out_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] resolved_mac;
  logic [IP_W-1:0]  next_hop_ip;
  logic             send_reply;
  logic             request_needed;

  modport source (
    output valid, hit, resolved_mac, next_hop_ip, send_reply, request_needed,
    input  ready
  );

  modport sink (
    input  valid, hit, resolved_mac, next_hop_ip, send_reply, request_needed,
    output ready
  );

endinterface

>>> hdl/arpc_ram.sv
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/arp_cache_learn_resolve_top.sv
// arp cache: CACHE_ENTRIES ip-to-mac bindings, ip and mac kept together in one
// synchronous ram, valid bits in flops cleared by reset. a learn request
// (operation 0) rewrites the mac of a valid entry holding peer_ip, else takes
// the lowest free entry, else overwrites entry 0; it also raises send_reply
// for an arp request (opcode 1) whose target is local_ip. a resolve request
// (operation 1) picks peer_ip when it is on the local subnet, gateway_ip
// otherwise, looks it up and returns the mac or request_needed. one request
// at a time: every request walks the whole table, one ram read a cycle, and
// a learn then writes its entry back to the ram before its result is loaded.
// the next request is taken as soon as the result is in the output register,
// even while that result still waits for out_chan.ready. configuration is
// written through cfg_we / cfg_index / cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce it.
module arp_cache_learn_resolve_top #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  arpc_in_if.sink                        in_chan,
  arpc_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import arpc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int ENT_W = IP_W + MAC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // configuration
  logic [IP_W-1:0] local_ip_r;
  logic [IP_W-1:0] subnet_mask_r;
  logic [IP_W-1:0] gateway_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r    <= '0;
      subnet_mask_r <= '0;
      gateway_ip_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_IP:    local_ip_r    <= cfg_wdata;
        CFG_SUBNET_MASK: subnet_mask_r <= cfg_wdata;
        CFG_GATEWAY_IP:  gateway_ip_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  state_t state_r, state_nxt;

  logic                     in_acc;
  logic                     ram_re;
  logic                     ram_we;
  logic                     load_out;
  logic                     scan_end;
  logic [IDX_W-1:0]         wr_idx;
  logic [IDX_W-1:0]         ram_addr;
  logic [ENT_W-1:0]         ram_rdata;
  logic [IP_W-1:0]          rd_ip;
  logic [MAC_W-1:0]         rd_mac;
  logic                     cmp_hit;

  // request held for the whole walk
  op_t              op_r;
  logic [IP_W-1:0]  key_r;
  logic [MAC_W-1:0] mac_r;
  logic             reply_r;

  // table walk
  logic [IDX_W-1:0]         issue_idx_r;
  logic                     issue_done_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     match_r;
  logic [IDX_W-1:0]         match_idx_r;
  logic [MAC_W-1:0]         hit_mac_r;
  logic                     free_r;
  logic [IDX_W-1:0]         free_idx_r;
  logic [CACHE_ENTRIES-1:0] valid_r;

  // result register
  logic             out_valid_r;
  logic             out_hit_r;
  logic [MAC_W-1:0] out_mac_r;
  logic [IP_W-1:0]  out_hop_r;
  logic             out_reply_r;
  logic             out_req_r;

  logic [IP_W-1:0]  next_hop;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign rd_ip    = ram_rdata[ENT_W-1 -: IP_W];
  assign rd_mac   = ram_rdata[MAC_W-1:0];
  assign cmp_hit  = cmp_vld_r && valid_r[cmp_idx_r] && (rd_ip == key_r);
  assign scan_end = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  // updating hit wins, then lowest free entry, then entry 0 of a full table
  assign wr_idx   = match_r ? match_idx_r : (free_r ? free_idx_r : '0);
  assign ram_addr = ram_we ? wr_idx : issue_idx_r;

  // on-subnet destinations go direct, everything else via the gateway
  assign next_hop = ((in_chan.peer_ip & subnet_mask_r) == (local_ip_r & subnet_mask_r))
                    ? in_chan.peer_ip : gateway_ip_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (op_r == OP_LEARN) ? ST_WRITE : ST_RESULT;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_chan.ready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_SCAN:   ram_re        = !issue_done_r;
      ST_WRITE:  ram_we        = 1'b1;
      ST_RESULT: load_out      = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture; the key is the sender ip for learn, the next hop for resolve
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_chan.operation);
      key_r   <= (op_t'(in_chan.operation) == OP_RESOLVE) ? next_hop : in_chan.peer_ip;
      mac_r   <= in_chan.peer_mac;
      reply_r <= (op_t'(in_chan.operation) == OP_LEARN) &&
                 (in_chan.arp_opcode == ARP_OPCODE_REQUEST) &&
                 (in_chan.target_ip == local_ip_r);
    end
  end

  // read issue and compare, one entry a cycle; the compare works on the registered ram read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_done_r <= 1'b1;
      cmp_vld_r    <= 1'b0;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
    end else if (in_acc) begin
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      cmp_vld_r <= ram_re;
      if (ram_re && (issue_idx_r == LAST_IDX)) begin
        issue_done_r <= 1'b1;
      end
      if (cmp_hit && !match_r) begin
        match_r <= 1'b1;
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      issue_idx_r <= '0;
    end else if (ram_re && (issue_idx_r != LAST_IDX)) begin
      issue_idx_r <= issue_idx_r + 1'b1;
    end
    if (ram_re) begin
      cmp_idx_r <= issue_idx_r;
    end
    if (cmp_hit && !match_r) begin
      match_idx_r <= cmp_idx_r;
      hit_mac_r   <= rd_mac;
    end
    if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  arpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata ({key_r, mac_r}),
    .rdata (ram_rdata)
  );

  // output register, parts the walk from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r   <= (op_r == OP_RESOLVE) && match_r;
      out_mac_r   <= ((op_r == OP_RESOLVE) && match_r) ? hit_mac_r : '0;
      out_hop_r   <= (op_r == OP_RESOLVE) ? key_r : '0;
      out_reply_r <= reply_r;
      out_req_r   <= (op_r == OP_RESOLVE) && !match_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.hit            = out_hit_r;
  assign out_chan.resolved_mac   = out_mac_r;
  assign out_chan.next_hop_ip    = out_hop_r;
  assign out_chan.send_reply     = out_reply_r;
  assign out_chan.request_needed = out_req_r;

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN) && !cmp_vld_r)
    else $error("accepted request did not start a table walk");

  a_write_only_learn: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (op_r == OP_LEARN) && issue_done_r && !cmp_vld_r)
    else $error("ram write outside a finished learn walk");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(wr_idx)])
    else $error("written entry not marked valid");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESULT))
    else $error("result presented without a finished walk");

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_req_r) && !(out_reply_r && (out_hit_r || out_req_r)))
    else $error("inconsistent result flags");

endmodule
